FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

FILE: sv/md5_pkg.sv
package md5_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_FILL,
        ST_ROUND,
        ST_PAD,
        ST_OUT0,
        ST_OUT1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_en;        // write wr_byte at the fill position
        logic [7:0] wr_byte;
        logic       add_len;      // add eight to the bit count
        logic       start_round;  // load working words from chain words
        logic       do_round;     // run one compression round
        logic       fold;         // add working words into chain words
        logic       clear;        // return to the reset state
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill_pos;
        logic [5:0] round_idx;
        logic [63:0] bit_len;
    } dp_stat_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // Per-round additive constants.
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        return k[i];
    endfunction

    // Rotate amount for a round.
    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

FILE: sv/md5_datapath.sv
`include "assert_macros.svh"

module md5_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::dp_cmd_t   cmd,
    output md5_pkg::dp_stat_t  stat,
    output logic [127:0]       digest
);

    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [63:0] len_reg;
    logic [31:0] words [16];

    // Block buffer kept as sixteen little-endian words.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            words[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= cmd.wr_byte;
        end
    end

    // Round function and new B.
    logic [31:0] f_val, sum_val, rot_val, b_next;
    logic [4:0]  s_amt;
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        s_amt   = md5_pkg::round_s(round_reg);
        sum_val = a_reg + f_val + md5_pkg::round_k(round_reg)
                + words[md5_pkg::round_g(round_reg)];
        rot_val = (sum_val << s_amt) | (sum_val >> (6'd32 - {1'b0, s_amt}));
        b_next  = b_reg + rot_val;
    end

    // Control counters and chaining registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
            fill_reg     <= '0;
            round_reg    <= '0;
            len_reg      <= '0;
        end
        else if (cmd.clear)
        begin
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
            fill_reg     <= '0;
            round_reg    <= '0;
            len_reg      <= '0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.add_len)
            begin
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.start_round)
            begin
                round_reg <= '0;
            end
            else if (cmd.do_round)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    // Working words.
    always_ff @(posedge clk)
    begin
        if (cmd.start_round)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.do_round)
        begin
            a_reg <= d_reg;
            b_reg <= b_next;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    assign stat.fill_pos  = fill_reg;
    assign stat.round_idx = round_reg;
    assign stat.bit_len   = len_reg;
    assign digest = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};

    // A block is never written while rounds run, and rounds never fold mid-block.
    `ASSERT_IMPL(a_no_write_in_round, clk, rst_n, cmd.do_round, !cmd.wr_en)
    `ASSERT_IMPL(a_fold_at_block, clk, rst_n, cmd.fold, fill_reg == 6'd0)

endmodule

FILE: sv/md5_ctrl.sv
`include "assert_macros.svh"

module md5_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_tvalid,
    output logic               in_tready,
    input  logic [7:0]         in_byte,
    input  logic               in_byte_valid,
    input  logic               in_last,
    input  logic               out_tready,
    output logic               out_tvalid,
    output logic               out_half,
    input  md5_pkg::dp_stat_t  stat,
    output md5_pkg::dp_cmd_t   cmd
);

    md5_pkg::state_t state_reg, state_next;
    logic closing_reg, closing_next;   // message closed, padding, compression or output in progress
    logic len_phase_reg, len_phase_next;
    logic len_block_reg, len_block_next;   // current pad block carries the length
    logic [63:0] len_hold_reg, len_hold_next;
    logic fold_reg;
    logic pad_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_FILL;
            closing_reg   <= 1'b0;
            len_phase_reg <= 1'b0;
            len_block_reg <= 1'b0;
            len_hold_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            closing_reg   <= closing_next;
            len_phase_reg <= len_phase_next;
            len_block_reg <= len_block_next;
            len_hold_reg  <= len_hold_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        closing_next   = closing_reg;
        len_phase_next = len_phase_reg;
        len_block_next = len_block_reg;
        len_hold_next  = len_hold_reg;
        cmd            = '0;
        in_tready      = 1'b0;
        out_tvalid     = 1'b0;
        out_half       = 1'b0;
        unique case (state_reg)
            md5_pkg::ST_FILL:
            begin
                // The cycle after the last round folds the working words.
                cmd.fold = fold_reg;
                if (closing_reg)
                begin
                    // Resume padding, or start the output once the length went in.
                    if (pad_done_reg)
                    begin
                        state_next = md5_pkg::ST_OUT0;
                    end
                    else
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
                else
                begin
                    in_tready = 1'b1;
                    if (in_tvalid)
                    begin
                        if (in_byte_valid)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_byte = in_byte;
                            cmd.add_len = 1'b1;
                        end
                        if (in_last)
                        begin
                            closing_next   = 1'b1;
                            len_phase_next = 1'b0;
                            len_block_next = 1'b0;
                            len_hold_next  = stat.bit_len + (in_byte_valid ? 64'd8 : 64'd0);
                        end
                        if (in_byte_valid && stat.fill_pos == 6'd63)
                        begin
                            cmd.start_round = 1'b1;
                            state_next      = md5_pkg::ST_ROUND;
                        end
                        else if (in_last)
                        begin
                            state_next = md5_pkg::ST_PAD;
                        end
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                cmd.wr_en = 1'b1;
                if (stat.fill_pos >= 6'd56 && len_phase_reg && len_block_reg)
                begin
                    cmd.wr_byte = len_hold_reg[8*stat.fill_pos[2:0] +: 8];
                end
                else if (!len_phase_reg)
                begin
                    cmd.wr_byte    = 8'h80;
                    len_phase_next = 1'b1;
                    // The length fits behind the marker only below byte 56.
                    if (stat.fill_pos < 6'd56)
                    begin
                        len_block_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_byte = 8'h00;
                end
                if (stat.fill_pos == 6'd63)
                begin
                    cmd.start_round = 1'b1;
                    state_next      = md5_pkg::ST_ROUND;
                    // A block without the length pushes it into the next block.
                    if (!len_block_reg)
                    begin
                        len_block_next = 1'b1;
                    end
                end
            end
            md5_pkg::ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (stat.round_idx == 6'd63)
                begin
                    state_next = md5_pkg::ST_FILL;
                end
            end
            md5_pkg::ST_OUT0:
            begin
                out_tvalid = 1'b1;
                if (out_tready)
                begin
                    state_next = md5_pkg::ST_OUT1;
                end
            end
            md5_pkg::ST_OUT1:
            begin
                out_tvalid = 1'b1;
                out_half   = 1'b1;
                if (out_tready)
                begin
                    cmd.clear    = 1'b1;
                    closing_next = 1'b0;
                    state_next   = md5_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_FILL;
            end
        endcase
    end

    // Fold pending after the final round; padding complete marker.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg     <= 1'b0;
            pad_done_reg <= 1'b0;
        end
        else
        begin
            fold_reg <= (state_reg == md5_pkg::ST_ROUND) && (stat.round_idx == 6'd63);
            if (cmd.clear)
            begin
                pad_done_reg <= 1'b0;
            end
            else if (state_reg == md5_pkg::ST_PAD && len_block_reg && stat.fill_pos == 6'd63)
            begin
                pad_done_reg <= 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_out_only_closing, clk, rst_n, out_tvalid, closing_reg)
    `ASSERT_IMPL(a_no_input_in_round, clk, rst_n, state_reg == md5_pkg::ST_ROUND, !in_tready)
    `ASSERT_ALWAYS(a_fold_no_round, clk, rst_n, !(cmd.fold && cmd.do_round))

endmodule

FILE: sv/md5_stream_hasher.sv
// Streaming MD5 hasher.
// Input channel s_axis: one item per message byte. tdata[7:0] carries the
// byte, tuser marks whether the byte is part of the message, and tlast closes
// the message (an item with tuser low and tlast high closes it as it stands).
// Output channel m_axis: two items per message, tdata holding eight digest
// bytes with the first byte in the low bits, tuser the half index and tlast
// set on the second half.
// Bytes are taken one per cycle while the block buffer fills. The 64th byte of
// a block starts the compression, one round per cycle in a single round unit,
// and s_axis_tready stays low while the rounds run. Closing writes the padding
// one byte a cycle and runs one or two compressions, the last after the length
// bytes; the first digest half is offered once that compression is folded into
// the chaining words. After the second half is taken the block is back in its
// reset state. While m_axis_tready is low the digest holds and no input is
// taken. Reset loads the MD5 initial chaining words and clears the counts.
module md5_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_half
    output logic        m_axis_tuser,   // half_index
    output logic        m_axis_tlast    // digest_done
);

    md5_pkg::dp_cmd_t  cmd;
    md5_pkg::dp_stat_t stat;
    logic [127:0]      digest;
    logic              half;

    md5_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_tvalid     (s_axis_tvalid),
        .in_tready     (s_axis_tready),
        .in_byte       (s_axis_tdata),
        .in_byte_valid (s_axis_tuser),
        .in_last       (s_axis_tlast),
        .out_tready    (m_axis_tready),
        .out_tvalid    (m_axis_tvalid),
        .out_half      (half),
        .stat          (stat),
        .cmd           (cmd)
    );

    md5_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .digest (digest)
    );

    // Select the digest half on the output.
    assign m_axis_tdata = half ? digest[127:64] : digest[63:0];
    assign m_axis_tuser = half;
    assign m_axis_tlast = half;

endmodule

FILE: dv/md5_stream_hasher_test.sv
module md5_stream_hasher_test;

    // Chaining words at the start of a message.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Expected digest halves.
    typedef struct packed {
        logic [63:0] half_bytes;
        logic        half_idx;
        logic        done;
    } digest_half_t;

    // One input item.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       closes;
    } msg_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // byte_valid
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // digest_half
    logic        m_axis_tuser;   // half_index
    logic        m_axis_tlast;   // digest_done

    md5_stream_hasher u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msg_item_t    pending_items[$];
    digest_half_t expected_digests[$];

    // Predictor state.
    logic [31:0] chain[4];
    logic [7:0]  block_buf[64];
    logic [63:0] msg_bits;
    int unsigned fill_pos;

    int unsigned error_count;
    int unsigned digests_seen;
    int unsigned bytes_sent;
    int unsigned hold_cycles;
    bit          stim_done;
    bit          pause_for_drain;
    bit          long_hold_req;

    // Round constants and rotate amounts from the MD5 definition.
    localparam logic [31:0] RK[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int RS[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Runs the 64-round compression on the collected block.
    task automatic compress_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, tmp;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (b & d) | (c & ~d);
                g = (5 * i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            tmp = d;
            d = c;
            c = b;
            b = b + rotl(a + f + RK[i] + w[g], RS[((i / 16) * 4) + (i % 4)]);
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic append_byte(input logic [7:0] v);
        block_buf[fill_pos] = v;
        fill_pos++;
        if (fill_pos == 64)
        begin
            compress_block();
            fill_pos = 0;
        end
    endtask

    task automatic restart_digest();
        chain[0] = IV_A;
        chain[1] = IV_B;
        chain[2] = IV_C;
        chain[3] = IV_D;
        msg_bits = '0;
        fill_pos = 0;
    endtask

    // Applies one accepted item to the predictor and queues any digest.
    task automatic predict_digest(input msg_item_t it);
        logic [63:0] len;
        digest_half_t h;
        if (it.has_byte)
        begin
            msg_bits += 64'd8;
            append_byte(it.data);
        end
        if (it.closes)
        begin
            len = msg_bits;
            append_byte(8'h80);
            while (fill_pos != 56)
                append_byte(8'h00);
            for (int k = 0; k < 8; k++)
                append_byte(len[8*k +: 8]);
            h.half_bytes = {chain[1], chain[0]};
            h.half_idx = 1'b0;
            h.done = 1'b0;
            expected_digests.push_back(h);
            h.half_bytes = {chain[3], chain[2]};
            h.half_idx = 1'b1;
            h.done = 1'b1;
            expected_digests.push_back(h);
            restart_digest();
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic queue_item(input logic [7:0] d, input logic v, input logic l);
        msg_item_t it;
        it.data = d;
        it.has_byte = v;
        it.closes = l;
        pending_items.push_back(it);
    endtask

    // Queues a message of n random bytes, with occasional idle items; the closing item carries a byte or not.
    task automatic queue_message(input int n);
        bit close_empty;
        close_empty = 1'($urandom_range(0, 1));
        if (n == 0)
            close_empty = 1;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, (i == n - 1) && !close_empty);
        end
        if (close_empty)
            queue_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers pending items with random gaps.
    int unsigned send_gap;
    msg_item_t   cur_item;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_digest(cur_item);
                void'(pending_items.pop_front());
                send_gap = gap_len();
                if (cur_item.has_byte)
                    bytes_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Hold the offered item.
            end
            else if (send_gap > 0 || pending_items.size() == 0 ||
                     (pause_for_drain && expected_digests.size() != 0))
            begin
                if (send_gap > 0)
                    send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                cur_item = pending_items[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= cur_item.data;
                s_axis_tuser <= cur_item.has_byte;
                s_axis_tlast <= cur_item.closes;
            end
        end
    end

    // Monitor: random backpressure and field checks.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_digests.size() == 0)
                    report_mismatch("digest half with nothing expected");
                else
                begin
                    digest_half_t e;
                    e = expected_digests.pop_front();
                    if (m_axis_tdata !== e.half_bytes)
                        report_mismatch($sformatf("digest %h, expected %h",
                                                  m_axis_tdata, e.half_bytes));
                    if (m_axis_tuser !== e.half_idx)
                        report_mismatch("half index differs");
                    if (m_axis_tlast !== e.done)
                        report_mismatch("done flag differs");
                    digests_seen++;
                end
            end
            if (long_hold_req && hold_cycles == 0)
            begin
                hold_cycles = 2000;
                long_hold_req = 0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                hold_cycles = gap_len();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int lens[5];
        error_count = 0;
        digests_seen = 0;
        bytes_sent = 0;
        stim_done = 0;
        pause_for_drain = 0;
        long_hold_req = 0;
        restart_digest();
        for (int i = 0; i < 64; i++)
            block_buf[i] = '0;

        // Directed: empty message, idle items, extreme bytes, padding boundaries.
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'h55, 1'b1, 1'b0);
        queue_item(8'haa, 1'b0, 1'b1);
        lens = '{55, 56, 63, 64, 120};
        foreach (lens[i])
            queue_message(lens[i]);

        // Long hold-off on the receiver while the sender keeps offering.
        long_hold_req = 1;
        for (int i = 0; i < 6; i++)
            queue_message($urandom_range(0, 20));

        // Random messages, mostly short.
        while (bytes_sent + pending_items.size() < 500)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_message($urandom_range(50, 100));
            else
                queue_message($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0)
                queue_item(8'($urandom), 1'b0, 1'b0);
        end

        wait (pending_items.size() < 40 && expected_digests.size() != 0);
        pause_for_drain = 1;
        wait (expected_digests.size() == 0);
        pause_for_drain = 0;

        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_digests.size() == 0);
        repeat (300) @(posedge clk);
        $display("Checked %0d digest halves over %0d message bytes,", digests_seen, bytes_sent);
        $display("including empty, padding-boundary and multi-block messages.");
        if (error_count == 0 && expected_digests.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
